// ----- rtl/gcfd_pkg.sv -----
package gcfd_pkg;

   localparam int DATA_W   = 10;
   localparam int DATA_MAX = (1 << DATA_W) - 1;
   localparam int CTR_W    = DATA_W + 1;
   localparam int SQR_W    = 2 * DATA_W;
   localparam int STAT_W   = 2;
   localparam int FALL_W   = 2;

   localparam logic [STAT_W-1:0] ST_PENDING    = 2'd0;
   localparam logic [STAT_W-1:0] ST_CALIBRATED = 2'd1;
   localparam logic [STAT_W-1:0] ST_FAILED     = 2'd2;

   localparam logic [FALL_W-1:0] FALL_STANDING = 2'd0;
   localparam logic [FALL_W-1:0] FALL_FORWARD  = 2'd1;
   localparam logic [FALL_W-1:0] FALL_BACKWARD = 2'd2;

   localparam logic [DATA_W-1:0] CENTER_RESET = 10'd512;

   localparam logic REG_FWD_LIMIT = 1'b0;
   localparam logic REG_BWD_LIMIT = 1'b1;

   typedef struct packed {
      logic              read_ok;
      logic              motion_enabled;
      logic [DATA_W-1:0] gyro_fb_raw;
      logic [DATA_W-1:0] gyro_rl_raw;
      logic [DATA_W-1:0] accel_fb_raw;
      logic [SQR_W-1:0]  gyro_fb_sq;
      logic [SQR_W-1:0]  gyro_rl_sq;
   } item_type;

   typedef struct packed {
      logic start;
      logic ack;
   } cal_ctl_type;

   typedef struct packed {
      logic              done;
      logic              pass;
      logic [DATA_W-1:0] fb_mean;
      logic [DATA_W-1:0] rl_mean;
   } cal_res_type;

endpackage

// ----- rtl/gcfd_if.sv -----
interface gcfd_req_if import gcfd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              read_ok;
   logic              motion_enabled;
   logic [DATA_W-1:0] gyro_fb_raw;
   logic [DATA_W-1:0] gyro_rl_raw;
   logic [DATA_W-1:0] accel_fb_raw;

   modport source (
      output valid, read_ok, motion_enabled, gyro_fb_raw, gyro_rl_raw, accel_fb_raw,
      input  ready
   );
   modport sink (
      input  valid, read_ok, motion_enabled, gyro_fb_raw, gyro_rl_raw, accel_fb_raw,
      output ready
   );
endinterface

interface gcfd_rsp_if import gcfd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STAT_W-1:0]        calib_state;
   logic                     gyro_valid;
   logic signed [CTR_W-1:0]  gyro_fb_centered;
   logic signed [CTR_W-1:0]  gyro_rl_centered;
   logic                     fall_valid;
   logic [FALL_W-1:0]        fall_state;
   logic [DATA_W-1:0]        fb_center_out;
   logic [DATA_W-1:0]        rl_center_out;

   modport source (
      output valid, calib_state, gyro_valid, gyro_fb_centered, gyro_rl_centered,
             fall_valid, fall_state, fb_center_out, rl_center_out,
      input  ready
   );
   modport sink (
      input  valid, calib_state, gyro_valid, gyro_fb_centered, gyro_rl_centered,
             fall_valid, fall_state, fb_center_out, rl_center_out,
      output ready
   );
endinterface

// ----- rtl/gyro_calibration_and_fall_detect_unit.sv -----
// Gyro bias calibration and accelerometer fall detection. Every request gives exactly one
// response; requests are taken one per cycle while the queue has room, and each passes
// through the two-entry request queue, then the response register. The exception is the
// request that follows a full window of GYRO_WINDOW good gyro samples: it waits in the queue
// until the decision unit has finished: it launches, forms the four products of the spread
// test, then does the reciprocal multiplications that yield both means; once the queue is
// full the request side stalls. The accelerometer ring is a memory of ACCEL_WINDOW entries
// with one valid flag per entry, so it reads as 512 from reset with no clearing pass. Write
// the limit registers only while idle.
module gyro_calibration_and_fall_detect_unit import gcfd_pkg::*; #(
   parameter int GYRO_WINDOW  = 100,
   parameter int ACCEL_WINDOW = 30
) (
   input  logic              clock,
   input  logic              reset,
   gcfd_req_if.sink          req_chan,
   gcfd_rsp_if.source        rsp_chan,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [DATA_W-1:0] csr_wr_data
);

   logic     q_pop;
   logic     q_avail;
   item_type q_head;

   gcfd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_pop    (q_pop),
      .q_avail  (q_avail),
      .q_head   (q_head)
   );

   gcfd_back #(
      .GYRO_WINDOW  (GYRO_WINDOW),
      .ACCEL_WINDOW (ACCEL_WINDOW)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .q_avail     (q_avail),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_chan    (rsp_chan)
   );

`ifndef ASSERT_OFF
   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_avail)
      else $error("queue popped while empty");

   a_fall_needs_cal: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.fall_valid) |-> (rsp_chan.calib_state == ST_CALIBRATED))
      else $error("fall state reported while not calibrated");

   a_gyro_needs_fall: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.gyro_valid) |-> rsp_chan.fall_valid)
      else $error("centered gyro reported without fall evaluation");

   a_cal_sticks: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && (rsp_chan.calib_state == ST_CALIBRATED))
      |=> (!rsp_chan.valid || (rsp_chan.calib_state == ST_CALIBRATED)))
      else $error("calibrated state left before reset");
`endif

endmodule

// ----- rtl/gcfd_front.sv -----
module gcfd_front import gcfd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   gcfd_req_if.sink   req_chan,
   input  logic       q_pop,
   output logic       q_avail,
   output item_type   q_head
);

   localparam int QUEUE_DEPTH = 2;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   logic [QCNT_W-1:0] q_count_ff, q_count_in;
   logic              q_wr_ptr_ff, q_wr_ptr_in;
   logic              q_rd_ptr_ff, q_rd_ptr_in;
   item_type          q_mem_ff [QUEUE_DEPTH];
   item_type          item_in;
   logic              push;

   assign req_chan.ready = (q_count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push           = req_chan.valid && req_chan.ready;

   // squares go into the queue so the back end only adds
   always_comb begin
      item_in.read_ok        = req_chan.read_ok;
      item_in.motion_enabled = req_chan.motion_enabled;
      item_in.gyro_fb_raw    = req_chan.gyro_fb_raw;
      item_in.gyro_rl_raw    = req_chan.gyro_rl_raw;
      item_in.accel_fb_raw   = req_chan.accel_fb_raw;
      item_in.gyro_fb_sq     = SQR_W'(req_chan.gyro_fb_raw) * SQR_W'(req_chan.gyro_fb_raw);
      item_in.gyro_rl_sq     = SQR_W'(req_chan.gyro_rl_raw) * SQR_W'(req_chan.gyro_rl_raw);
   end

   always_comb begin
      q_wr_ptr_in = push  ? ~q_wr_ptr_ff : q_wr_ptr_ff;
      q_rd_ptr_in = q_pop ? ~q_rd_ptr_ff : q_rd_ptr_ff;
      case ({push, q_pop})
         2'b10:   q_count_in = q_count_ff + QCNT_W'(1);
         2'b01:   q_count_in = q_count_ff - QCNT_W'(1);
         default: q_count_in = q_count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_count_ff  <= '0;
         q_wr_ptr_ff <= 1'b0;
         q_rd_ptr_ff <= 1'b0;
      end else begin
         q_count_ff  <= q_count_in;
         q_wr_ptr_ff <= q_wr_ptr_in;
         q_rd_ptr_ff <= q_rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[q_wr_ptr_ff] <= item_in;
      end
   end

   assign q_avail = (q_count_ff != '0);
   assign q_head  = q_mem_ff[q_rd_ptr_ff];

endmodule

// ----- rtl/gcfd_cal_unit.sv -----
module gcfd_cal_unit import gcfd_pkg::*; #(
   parameter int GYRO_WINDOW = 100
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  cal_ctl_type                                       cal_ctl,
   input  logic [$clog2(DATA_MAX*GYRO_WINDOW+1)-1:0]          fb_sum,
   input  logic [$clog2(DATA_MAX*GYRO_WINDOW+1)-1:0]          rl_sum,
   input  logic [$clog2(DATA_MAX*DATA_MAX*GYRO_WINDOW+1)-1:0] fb_sq_sum,
   input  logic [$clog2(DATA_MAX*DATA_MAX*GYRO_WINDOW+1)-1:0] rl_sq_sum,
   output cal_res_type                                       cal_res
);

   localparam int SUM_W  = $clog2(DATA_MAX * GYRO_WINDOW + 1);
   localparam int SQ_W   = $clog2(DATA_MAX * DATA_MAX * GYRO_WINDOW + 1);
   localparam int A_W    = SQ_W + $clog2(GYRO_WINDOW + 1);
   localparam int B_W    = 2 * SUM_W;
   localparam int PROD_W = (A_W > B_W) ? A_W : B_W;

   // floor(sum/N) as (sum * RECIP) >> SHIFT, exact for every sum below 2^SUM_W
   localparam int SHIFT  = SUM_W + $clog2(GYRO_WINDOW);
   localparam int RCP_W  = SUM_W + 2;
   localparam int QP_W   = SUM_W + RCP_W;

   localparam logic [PROD_W-1:0] SPREAD_LIM = PROD_W'(4 * GYRO_WINDOW * GYRO_WINDOW);
   localparam logic [RCP_W-1:0]  RECIP      =
      RCP_W'(((longint'(1) << SHIFT) + longint'(GYRO_WINDOW) - 1) / longint'(GYRO_WINDOW));

   localparam logic [1:0] CS_IDLE = 2'd0;
   localparam logic [1:0] CS_MUL  = 2'd1;
   localparam logic [1:0] CS_DIV  = 2'd2;
   localparam logic [1:0] CS_DONE = 2'd3;

   logic [1:0]        cs_ff, cs_in;
   logic [PROD_W-1:0] a_fb_ff, a_fb_in, a_rl_ff, a_rl_in;
   logic [PROD_W-1:0] b_fb_ff, b_fb_in, b_rl_ff, b_rl_in;
   logic [DATA_W-1:0] q_fb_ff, q_fb_in, q_rl_ff, q_rl_in;
   logic              pass_ff, pass_in;
   logic [QP_W-1:0]   qp_fb, qp_rl;

   // N*sumsq - sum^2 < 4*N^2 is sd < 2 without a root
   function automatic logic spread_small(input logic [PROD_W-1:0] a, input logic [PROD_W-1:0] b);
      return (a < b) || ((a - b) < SPREAD_LIM);
   endfunction

   assign qp_fb = QP_W'(fb_sum) * QP_W'(RECIP);
   assign qp_rl = QP_W'(rl_sum) * QP_W'(RECIP);

   always_comb begin
      cs_in     = cs_ff;
      a_fb_in   = a_fb_ff;
      a_rl_in   = a_rl_ff;
      b_fb_in   = b_fb_ff;
      b_rl_in   = b_rl_ff;
      q_fb_in   = q_fb_ff;
      q_rl_in   = q_rl_ff;
      pass_in   = pass_ff;
      case (cs_ff)
         CS_IDLE: begin
            if (cal_ctl.start) begin
               cs_in = CS_MUL;
            end
         end
         CS_MUL: begin
            a_fb_in   = PROD_W'(fb_sq_sum) * PROD_W'(GYRO_WINDOW);
            a_rl_in   = PROD_W'(rl_sq_sum) * PROD_W'(GYRO_WINDOW);
            b_fb_in   = PROD_W'(fb_sum) * PROD_W'(fb_sum);
            b_rl_in   = PROD_W'(rl_sum) * PROD_W'(rl_sum);
            cs_in     = CS_DIV;
         end
         CS_DIV: begin
            pass_in   = spread_small(a_fb_ff, b_fb_ff) && spread_small(a_rl_ff, b_rl_ff);
            q_fb_in   = qp_fb[SHIFT +: DATA_W];
            q_rl_in   = qp_rl[SHIFT +: DATA_W];
            cs_in     = CS_DONE;
         end
         CS_DONE: begin
            if (cal_ctl.ack) begin
               cs_in = CS_IDLE;
            end
         end
         default: cs_in = CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cs_ff   <= CS_IDLE;
      end else begin
         cs_ff   <= cs_in;
      end
   end

   always_ff @(posedge clock) begin
      a_fb_ff   <= a_fb_in;
      a_rl_ff   <= a_rl_in;
      b_fb_ff   <= b_fb_in;
      b_rl_ff   <= b_rl_in;
      q_fb_ff   <= q_fb_in;
      q_rl_ff   <= q_rl_in;
      pass_ff   <= pass_in;
   end

   assign cal_res.done    = (cs_ff == CS_DONE);
   assign cal_res.pass    = pass_ff;
   assign cal_res.fb_mean = q_fb_ff;
   assign cal_res.rl_mean = q_rl_ff;

endmodule

// ----- rtl/gcfd_back.sv -----
module gcfd_back import gcfd_pkg::*; #(
   parameter int GYRO_WINDOW  = 100,
   parameter int ACCEL_WINDOW = 30
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [DATA_W-1:0] csr_wr_data,
   input  logic              q_avail,
   input  item_type          q_head,
   output logic              q_pop,
   gcfd_rsp_if.source        rsp_chan
);

   localparam int CNT_W = $clog2(GYRO_WINDOW + 1);
   localparam int SUM_W = $clog2(DATA_MAX * GYRO_WINDOW + 1);
   localparam int SQ_W  = $clog2(DATA_MAX * DATA_MAX * GYRO_WINDOW + 1);
   localparam int ACC_W = $clog2(DATA_MAX * ACCEL_WINDOW + 1);
   localparam int THR_W = $clog2((DATA_MAX + 1) * ACCEL_WINDOW + 1);
   localparam int PTR_W = (ACCEL_WINDOW > 1) ? $clog2(ACCEL_WINDOW) : 1;

   localparam logic [ACC_W-1:0] ACC_SUM_RESET = ACC_W'(ACCEL_WINDOW * int'(CENTER_RESET));
   localparam logic [THR_W-1:0] BWD_THR_RESET = THR_W'((DATA_MAX + 1) * ACCEL_WINDOW);

   logic [STAT_W-1:0] status_ff, status_in, status_mid;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SUM_W-1:0]  fb_sum_ff, fb_sum_in, rl_sum_ff, rl_sum_in;
   logic [SQ_W-1:0]   fb_sq_ff, fb_sq_in, rl_sq_ff, rl_sq_in;
   logic [DATA_W-1:0] fb_center_ff, rl_center_ff, fb_center_mid, rl_center_mid;
   logic [PTR_W-1:0]  ptr_ff, ptr_in, ptr_next;
   logic [ACC_W-1:0]  acc_sum_ff, acc_sum_in, acc_sum_new;
   logic [THR_W-1:0]  fwd_thr_ff, fwd_thr_in, bwd_thr_ff, bwd_thr_in, cmp_sum;

   logic [DATA_W-1:0]       win_mem [ACCEL_WINDOW];
   logic [ACCEL_WINDOW-1:0] win_vld_ff;
   logic [DATA_W-1:0]       win_old_ff, win_old;
   logic                    win_old_vld_ff;
   logic                    win_we;

   logic                    rsp_valid_ff;
   logic [STAT_W-1:0]       rsp_status_ff;
   logic                    rsp_gyro_valid_ff, rsp_fall_valid_ff;
   logic signed [CTR_W-1:0] rsp_fb_ctr_ff, rsp_rl_ctr_ff, fb_ctr_in, rl_ctr_in;
   logic [FALL_W-1:0]       rsp_fall_ff, fall_in;
   logic [DATA_W-1:0]       rsp_fb_center_ff, rsp_rl_center_ff;

   logic        collecting, decide, out_free, run, gyro_ok;
   cal_ctl_type cal_ctl;
   cal_res_type cal_res;

   gcfd_cal_unit #(
      .GYRO_WINDOW (GYRO_WINDOW)
   ) u_cal (
      .clock     (clock),
      .reset     (reset),
      .cal_ctl   (cal_ctl),
      .fb_sum    (fb_sum_ff),
      .rl_sum    (rl_sum_ff),
      .fb_sq_sum (fb_sq_ff),
      .rl_sq_sum (rl_sq_ff),
      .cal_res   (cal_res)
   );

   assign collecting = (status_ff == ST_PENDING) || (status_ff == ST_FAILED);
   assign decide     = collecting && (count_ff == CNT_W'(GYRO_WINDOW));
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   // hold the request after a full window until the decision is ready
   assign q_pop      = q_avail && out_free && (!decide || cal_res.done);

   assign cal_ctl.start = decide;
   assign cal_ctl.ack   = q_pop && decide;

   always_comb begin
      status_mid    = status_ff;
      fb_center_mid = fb_center_ff;
      rl_center_mid = rl_center_ff;
      if (decide) begin
         if (cal_res.pass) begin
            status_mid    = ST_CALIBRATED;
            fb_center_mid = cal_res.fb_mean;
            rl_center_mid = cal_res.rl_mean;
         end else begin
            status_mid    = ST_FAILED;
            fb_center_mid = CENTER_RESET;
            rl_center_mid = CENTER_RESET;
         end
      end
   end

   assign run     = (status_mid == ST_CALIBRATED) && q_head.motion_enabled;
   assign gyro_ok = run && q_head.read_ok;
   assign win_we  = q_pop && gyro_ok;

   // gyro window accumulation
   always_comb begin
      count_in  = count_ff;
      fb_sum_in = fb_sum_ff;
      rl_sum_in = rl_sum_ff;
      fb_sq_in  = fb_sq_ff;
      rl_sq_in  = rl_sq_ff;
      status_in = status_ff;
      if (q_pop) begin
         status_in = status_mid;
         if (decide) begin
            count_in  = '0;
            fb_sum_in = '0;
            rl_sum_in = '0;
            fb_sq_in  = '0;
            rl_sq_in  = '0;
         end else if (collecting && q_head.read_ok) begin
            count_in  = count_ff + CNT_W'(1);
            fb_sum_in = fb_sum_ff + SUM_W'(q_head.gyro_fb_raw);
            rl_sum_in = rl_sum_ff + SUM_W'(q_head.gyro_rl_raw);
            fb_sq_in  = fb_sq_ff + SQ_W'(q_head.gyro_fb_sq);
            rl_sq_in  = rl_sq_ff + SQ_W'(q_head.gyro_rl_sq);
         end
      end
   end

   // accel ring: drop the oldest sample from the sum, add the new one
   assign win_old     = win_old_vld_ff ? win_old_ff : CENTER_RESET;
   assign acc_sum_new = acc_sum_ff - ACC_W'(win_old) + ACC_W'(q_head.accel_fb_raw);
   assign acc_sum_in  = win_we ? acc_sum_new : acc_sum_ff;
   assign ptr_next    = (ptr_ff == PTR_W'(ACCEL_WINDOW - 1)) ? '0 : ptr_ff + PTR_W'(1);
   assign ptr_in      = win_we ? ptr_next : ptr_ff;

   // floor(sum/N) < F  <=>  sum < F*N;  floor(sum/N) > B  <=>  sum >= (B+1)*N
   assign cmp_sum = THR_W'(acc_sum_in);
   always_comb begin
      if (!run) begin
         fall_in = FALL_STANDING;
      end else if (cmp_sum < fwd_thr_ff) begin
         fall_in = FALL_FORWARD;
      end else if (cmp_sum >= bwd_thr_ff) begin
         fall_in = FALL_BACKWARD;
      end else begin
         fall_in = FALL_STANDING;
      end
   end

   assign fb_ctr_in = gyro_ok ? signed'(CTR_W'(q_head.gyro_fb_raw) - CTR_W'(fb_center_mid)) : '0;
   assign rl_ctr_in = gyro_ok ? signed'(CTR_W'(q_head.gyro_rl_raw) - CTR_W'(rl_center_mid)) : '0;

   always_comb begin
      fwd_thr_in = fwd_thr_ff;
      bwd_thr_in = bwd_thr_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_FWD_LIMIT: fwd_thr_in = THR_W'(csr_wr_data) * THR_W'(ACCEL_WINDOW);
            REG_BWD_LIMIT: bwd_thr_in = (THR_W'(csr_wr_data) + THR_W'(1)) * THR_W'(ACCEL_WINDOW);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff    <= ST_PENDING;
         count_ff     <= '0;
         fb_sum_ff    <= '0;
         rl_sum_ff    <= '0;
         fb_sq_ff     <= '0;
         rl_sq_ff     <= '0;
         fb_center_ff <= CENTER_RESET;
         rl_center_ff <= CENTER_RESET;
         ptr_ff       <= '0;
         acc_sum_ff   <= ACC_SUM_RESET;
         fwd_thr_ff   <= '0;
         bwd_thr_ff   <= BWD_THR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         status_ff  <= status_in;
         count_ff   <= count_in;
         fb_sum_ff  <= fb_sum_in;
         rl_sum_ff  <= rl_sum_in;
         fb_sq_ff   <= fb_sq_in;
         rl_sq_ff   <= rl_sq_in;
         if (q_pop) begin
            fb_center_ff <= fb_center_mid;
            rl_center_ff <= rl_center_mid;
         end
         ptr_ff     <= ptr_in;
         acc_sum_ff <= acc_sum_in;
         fwd_thr_ff <= fwd_thr_in;
         bwd_thr_ff <= bwd_thr_in;
         if (q_pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_status_ff     <= status_mid;
         rsp_gyro_valid_ff <= gyro_ok;
         rsp_fb_ctr_ff     <= fb_ctr_in;
         rsp_rl_ctr_ff     <= rl_ctr_in;
         rsp_fall_valid_ff <= run;
         rsp_fall_ff       <= fall_in;
         rsp_fb_center_ff  <= fb_center_mid;
         rsp_rl_center_ff  <= rl_center_mid;
      end
   end

   // window memory with registered read of the next slot to retire
   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem[ptr_ff] <= q_head.accel_fb_raw;
      end
      if (win_we && (ptr_in == ptr_ff)) begin
         win_old_ff <= q_head.accel_fb_raw;
      end else begin
         win_old_ff <= win_mem[ptr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_vld_ff     <= '0;
         win_old_vld_ff <= 1'b0;
      end else begin
         if (win_we) begin
            win_vld_ff[ptr_ff] <= 1'b1;
         end
         win_old_vld_ff <= (win_we && (ptr_in == ptr_ff)) || win_vld_ff[ptr_in];
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.calib_state      = rsp_status_ff;
   assign rsp_chan.gyro_valid       = rsp_gyro_valid_ff;
   assign rsp_chan.gyro_fb_centered = rsp_fb_ctr_ff;
   assign rsp_chan.gyro_rl_centered = rsp_rl_ctr_ff;
   assign rsp_chan.fall_valid       = rsp_fall_valid_ff;
   assign rsp_chan.fall_state       = rsp_fall_ff;
   assign rsp_chan.fb_center_out    = rsp_fb_center_ff;
   assign rsp_chan.rl_center_out    = rsp_rl_center_ff;

endmodule
